/* hw/rtl/gabfs_pkg.sv */
// ----------------------------------------------------------------------------
// gabfs_pkg
// Shared types and constants for the graph adjacency and search engine.
// ----------------------------------------------------------------------------
package gabfs_pkg;

  localparam int MaxNodes  = 64;
  localparam int MaxDegree = 64;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int SlotW     = $clog2(MaxDegree);
  localparam int LenW      = $clog2(MaxDegree + 1);
  localparam int CountW    = $clog2(MaxNodes + 1);
  localparam int AddrW     = NodeW + SlotW;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_FRONT  = 2'd1,
    MODE_DEGREE = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_DUP_RD,
    S_DUP_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_CLEAR,
    S_POP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_MARK,
    S_FINISH
  } state_t;

endpackage

/* hw/rtl/graph_adjacency_bfs_engine.sv */
// ----------------------------------------------------------------------------
// graph_adjacency_bfs_engine
// Directed graph store with append, front insert, degree query and
// breadth-first search, driven by one sequencer.
// ----------------------------------------------------------------------------
// A range error shows its result in the cycle after start is taken, and busy
// is never raised. An append or a degree query first reads the length table,
// then passes the update state; the result follows in the next cycle. A front
// insert walks the list for duplicates, a read and a compare state per entry,
// and stops at a duplicate; else, unless the list is full, it shifts the list
// one entry at a time, a read and a write state per entry. A search first
// clears the 64 visited marks, one per cycle, setting only the start node's,
// then pops each reached node from the queue and scans its stored neighbors,
// a read, a check and a mark state each; results come out one per reached
// node. The receiver cannot stall: each result is shown for one cycle with
// done_strobe, and the last one appears in the cycle where busy falls.
module graph_adjacency_bfs_engine
  import gabfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic [1:0]  mode,
  input  logic [5:0]  node_u,
  input  logic [5:0]  node_v,
  output logic        done_strobe,
  output logic [5:0]  visited_node,
  output logic [6:0]  degree,
  output logic [1:0]  status,
  output logic        last
);

  state_t state, state_next;

  logic [6:0]        node_count;
  logic [CountW-1:0] eff_n;

  // Length table: a memory with registered reads; a valid bit per node makes
  // a never-written length read as zero.
  logic [LenW-1:0]     lengths [MaxNodes];
  logic [MaxNodes-1:0] len_vld;
  logic                len_we, len_re, len_hit;
  logic [NodeW-1:0]    len_raddr;
  logic [LenW-1:0]     len_raw, len;

  // Visited marks: a one-bit memory with registered reads.
  logic             marks [MaxNodes];
  logic             mark_we, mark_wdata, mark_rd;
  logic [NodeW-1:0] mark_waddr;

  mode_t            op;
  logic [NodeW-1:0] u_reg, v_reg, cur;
  logic [LenW-1:0]  idx;
  logic [CountW-1:0] head, tail;

  // List memory and queue memory.
  logic             l_we;
  logic [AddrW-1:0] l_waddr, l_raddr;
  logic [NodeW-1:0] l_wdata, l_rdata;
  logic             q_we;
  logic [NodeW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  gabfs_ram #(.Width(NodeW), .Depth(MaxNodes * MaxDegree)) u_lists (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  gabfs_ram #(.Width(NodeW), .Depth(MaxNodes)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign eff_n = (node_count > 7'(MaxNodes)) ? CountW'(MaxNodes)
                                             : CountW'(node_count);

  logic accept;
  logic range_err;
  logic nb_ok;
  assign accept = start && !busy;
  assign range_err = (CountW'(node_u) >= eff_n) ||
                     ((mode == MODE_APPEND || mode == MODE_FRONT) &&
                      (CountW'(node_v) >= eff_n));
  // The neighbor under test stays on l_rdata through the mark lookup.
  assign nb_ok = (CountW'(l_rdata) < eff_n) && !mark_rd &&
                 (tail < CountW'(MaxNodes));

  assign len = len_hit ? len_raw : '0;
  assign len_re = (state == S_IDLE) || (state == S_POP);
  assign len_raddr = (state == S_POP) ? q_rdata : node_u;
  assign len_we = (((state == S_UPDATE) && (op == MODE_APPEND)) ||
                   ((state == S_DUP_RD) && (idx >= len))) &&
                  (len < LenW'(MaxDegree));

  assign mark_we = (state == S_CLEAR) || ((state == S_SCAN_MARK) && nb_ok);
  assign mark_waddr = (state == S_CLEAR) ? idx[NodeW-1:0] : l_rdata;
  assign mark_wdata = (state == S_CLEAR) ? (idx[NodeW-1:0] == u_reg) : 1'b1;

  always_ff @(posedge clk) begin
    if (len_we) lengths[u_reg] <= len + 1'b1;
    if (len_re) begin
      len_raw <= lengths[len_raddr];
      len_hit <= len_vld[len_raddr];
    end
    if (mark_we) marks[mark_waddr] <= mark_wdata;
    mark_rd <= marks[l_rdata];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !range_err) begin
          case (mode_t'(mode))
            MODE_FRONT:  state_next = S_DUP_RD;
            MODE_SEARCH: state_next = S_CLEAR;
            default:     state_next = S_UPDATE;
          endcase
        end
      end
      S_UPDATE:   state_next = S_IDLE;
      S_DUP_RD:   state_next = (idx < len) ? S_DUP_CHK
                             : ((len >= LenW'(MaxDegree)) ? S_FINISH : S_SHIFT_RD);
      S_DUP_CHK:  state_next = (l_rdata == v_reg) ? S_FINISH : S_DUP_RD;
      S_SHIFT_RD: state_next = (idx == '0) ? S_FINISH : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_CLEAR:    state_next = (idx == LenW'(MaxNodes - 1)) ? S_POP : S_CLEAR;
      S_POP:      state_next = S_SCAN_RD;
      S_SCAN_RD:  state_next = (idx < len) ? S_SCAN_CHK
                             : ((head == tail) ? S_IDLE : S_POP);
      S_SCAN_CHK:  state_next = S_SCAN_MARK;
      S_SCAN_MARK: state_next = S_SCAN_RD;
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory ports and busy.
  always_comb begin
    l_we = 1'b0;
    l_waddr = {u_reg, idx[SlotW-1:0]};
    l_wdata = l_rdata;
    l_raddr = {u_reg, idx[SlotW-1:0]};
    q_we = 1'b0;
    q_waddr = tail[NodeW-1:0];
    q_wdata = l_rdata;
    q_raddr = head[NodeW-1:0];
    case (state)
      S_IDLE: begin
        q_waddr = '0;
        q_wdata = node_u;
        q_we = accept && !range_err && mode == MODE_SEARCH;
      end
      S_UPDATE: begin
        l_waddr = {u_reg, len[SlotW-1:0]};
        l_wdata = v_reg;
        l_we = (op == MODE_APPEND) && (len < LenW'(MaxDegree));
      end
      S_SHIFT_RD: begin
        l_raddr = {u_reg, SlotW'(idx - 1'b1)};
        if (idx == '0) begin
          l_we = 1'b1;
          l_waddr = {u_reg, {SlotW{1'b0}}};
          l_wdata = v_reg;
        end
      end
      S_SHIFT_WR: begin
        l_we = 1'b1;
        l_waddr = {u_reg, idx[SlotW-1:0]};
      end
      S_SCAN_RD:   l_raddr = {cur, idx[SlotW-1:0]};
      S_SCAN_CHK:  l_raddr = {cur, idx[SlotW-1:0]};
      S_SCAN_MARK: q_we = nb_ok;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= 7'd64;
      len_vld <= '0;
      done_strobe <= 1'b0;
    end else begin
      state <= state_next;
      done_strobe <= 1'b0;
      if (cfg_we) node_count <= cfg_wdata;
      if (len_we) len_vld[u_reg] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= mode_t'(mode);
            u_reg <= node_u;
            v_reg <= node_v;
            idx <= '0;
            visited_node <= '0;
            degree <= '0;
            last <= 1'b1;
            if (range_err) begin
              status <= ST_RANGE;
              done_strobe <= 1'b1;
            end else if (mode_t'(mode) == MODE_SEARCH) begin
              head <= '0;
              tail <= CountW'(1);
            end
          end
        end
        S_UPDATE: begin
          done_strobe <= 1'b1;
          if (op == MODE_DEGREE) begin
            status <= ST_DONE;
            degree <= 7'(len);
          end else if (len >= LenW'(MaxDegree)) begin
            status <= ST_FULL;
          end else begin
            status <= ST_DONE;
          end
        end
        S_DUP_RD: begin
          if (idx >= len) begin
            status <= (len >= LenW'(MaxDegree)) ? ST_FULL : ST_DONE;
          end
        end
        S_DUP_CHK: begin
          if (l_rdata == v_reg) status <= ST_DUP;
          idx <= idx + 1'b1;
        end
        S_SHIFT_WR: idx <= idx - 1'b1;
        S_CLEAR: idx <= idx + 1'b1;
        S_POP: begin
          cur <= q_rdata;
          idx <= '0;
          head <= head + 1'b1;
        end
        S_SCAN_RD: begin
          if (idx >= len) begin
            done_strobe <= 1'b1;
            visited_node <= cur;
            status <= ST_DONE;
            degree <= '0;
            last <= (head == tail);
          end
        end
        S_SCAN_MARK: begin
          if (nb_ok) tail <= tail + 1'b1;
          idx <= idx + 1'b1;
        end
        S_FINISH: done_strobe <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/gabfs_ram.sv */
// ----------------------------------------------------------------------------
// gabfs_ram
// Simple one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
module gabfs_ram #(
  parameter int Width = 6,
  parameter int Depth = 64,
  parameter int AddrBits = $clog2(Depth)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [Width-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [Width-1:0]    rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graph adjacency engine: a directed table of
// edge, degree and search operations, full-list and node-count cases, then
// random graph-building traffic with searches, predicted by a behavioral
// model of the lists and checked result by result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
  import gabfs_pkg::*;
();

  localparam int Limit = 30000000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = 7'd64;
  logic [1:0] mode = MODE_APPEND;
  logic [5:0] node_u = '0;
  logic [5:0] node_v = '0;
  logic       done_strobe;
  logic [5:0] visited_node;
  logic [6:0] degree;
  logic [1:0] status;
  logic       last;

  typedef struct packed {
    logic [5:0] node;
    logic [6:0] deg;
    logic [1:0] st;
    logic       lst;
  } graph_result_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] u;
    logic [5:0] v;
    logic       known;
    graph_result_t res;
  } table_row_t;

  graph_result_t pending_results[$];
  graph_result_t last_pred;
  logic [5:0]    adj_rows[MaxNodes][MaxDegree];
  int            adj_len[MaxNodes];
  int            active_nodes;
  int            errors = 0;
  int            cycles = 0;
  int            transfers = 0;
  int            searches = 0;
  int            result_count = 0;

  graph_adjacency_bfs_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mode(mode), .node_u(node_u), .node_v(node_v),
    .done_strobe(done_strobe), .visited_node(visited_node),
    .degree(degree), .status(status), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[graph_adjacency_bfs_engine] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic graph_result_t mk_res(logic [5:0] n, logic [6:0] d,
                                           logic [1:0] s, logic l);
    graph_result_t r;
    r.node = n; r.deg = d; r.st = s; r.lst = l;
    return r;
  endfunction

  // Applies one operation to the shadow graph and queues what it produces.
  task automatic predict_graph_op(input logic [1:0] op, input int u, input int v);
    int vis[MaxNodes];
    int fifo[$];
    int nd, i, nb, queued;
    logic dup;
    if (u >= active_nodes || (op <= MODE_FRONT && v >= active_nodes)) begin
      pending_results.push_back(mk_res(0, 0, ST_RANGE, 1'b1));
      return;
    end
    case (op)
      MODE_APPEND: begin
        if (adj_len[u] >= MaxDegree) begin
          pending_results.push_back(mk_res(0, 0, ST_FULL, 1'b1));
        end else begin
          adj_rows[u][adj_len[u]] = v[5:0];
          adj_len[u]++;
          pending_results.push_back(mk_res(0, 0, ST_DONE, 1'b1));
        end
      end
      MODE_FRONT: begin
        dup = 1'b0;
        for (i = 0; i < adj_len[u]; i++) if (adj_rows[u][i] == v) dup = 1'b1;
        if (dup) begin
          pending_results.push_back(mk_res(0, 0, ST_DUP, 1'b1));
        end else if (adj_len[u] >= MaxDegree) begin
          pending_results.push_back(mk_res(0, 0, ST_FULL, 1'b1));
        end else begin
          for (i = adj_len[u]; i > 0; i--) adj_rows[u][i] = adj_rows[u][i-1];
          adj_rows[u][0] = v[5:0];
          adj_len[u]++;
          pending_results.push_back(mk_res(0, 0, ST_DONE, 1'b1));
        end
      end
      MODE_DEGREE: begin
        pending_results.push_back(mk_res(0, adj_len[u][6:0], ST_DONE, 1'b1));
      end
      default: begin
        foreach (vis[k]) vis[k] = 0;
        vis[u] = 1;
        fifo.push_back(u);
        queued = 1;
        while (fifo.size() > 0) begin
          nd = fifo.pop_front();
          for (i = 0; i < adj_len[nd]; i++) begin
            nb = adj_rows[nd][i];
            if (nb < active_nodes && !vis[nb] && queued < MaxNodes) begin
              vis[nb] = 1;
              fifo.push_back(nb);
              queued++;
            end
          end
          pending_results.push_back(mk_res(nd[5:0], 0, ST_DONE, fifo.size() == 0));
        end
      end
    endcase
  endtask

  // Result checker: the engine cannot be held off, so every strobe is a transfer.
  always @(posedge clk) begin
    graph_result_t got, want;
    if (!rst && done_strobe) begin
      got = mk_res(visited_node, degree, status, last);
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
      end else begin
        want = pending_results.pop_front();
        if (got.node !== want.node)
          report_mismatch($sformatf("visited_node %0d, want %0d", got.node, want.node));
        if (got.deg !== want.deg)
          report_mismatch($sformatf("degree %0d, want %0d", got.deg, want.deg));
        if (got.st !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
        if (got.lst !== want.lst)
          report_mismatch($sformatf("last %0b, want %0b", got.lst, want.lst));
      end
    end
  end

  int burst_left = 0;

  task automatic send_op(input logic [1:0] op, input logic [5:0] u, input logic [5:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    while (busy) @(posedge clk);
    start <= 1'b1;
    mode <= op;
    node_u <= u;
    node_v <= v;
    predict_graph_op(op, u, v);
    last_pred = pending_results[pending_results.size()-1];
    transfers++;
    if (op == MODE_SEARCH) searches++;
    @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    active_nodes = (value > MaxNodes) ? MaxNodes : value;
    @(posedge clk);
  endtask

  table_row_t directed[$];

  function automatic table_row_t row(logic [1:0] op, logic [5:0] u, logic [5:0] v,
                                     logic known, graph_result_t r);
    table_row_t t;
    t.op = op; t.u = u; t.v = v; t.known = known; t.res = r;
    return t;
  endfunction

  // Builds a random graph piece focused on a few nodes so searches go deep.
  task automatic random_phase(input int count);
    int k, u, v, span;
    logic [1:0] op;
    span = (active_nodes < 12) ? active_nodes : $urandom_range(4, 16);
    for (k = 0; k < count; k++) begin
      op = $urandom_range(0, 9) < 5 ? 2'($urandom_range(0, 1)) :
           ($urandom_range(0, 1) ? MODE_DEGREE : MODE_SEARCH);
      if ($urandom_range(0, 9) == 0) begin
        u = $urandom_range(0, 63);
        v = $urandom_range(0, 63);
      end else begin
        u = $urandom_range(0, span - 1);
        v = $urandom_range(0, span - 1);
      end
      if ($urandom_range(0, 40) == 0) drain_results();
      send_op(op, u[5:0], v[5:0]);
    end
  endtask

  initial begin
    int i, r;
    table_row_t t;
    foreach (adj_len[k]) adj_len[k] = 0;
    active_nodes = MaxNodes;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(row(MODE_DEGREE, 0, 0, 1, mk_res(0, 0, ST_DONE, 1)));
    directed.push_back(row(MODE_SEARCH, 63, 0, 1, mk_res(63, 0, ST_DONE, 1)));
    directed.push_back(row(MODE_APPEND, 0, 1, 1, mk_res(0, 0, ST_DONE, 1)));
    directed.push_back(row(MODE_APPEND, 0, 1, 1, mk_res(0, 0, ST_DONE, 1)));
    directed.push_back(row(MODE_FRONT, 0, 1, 1, mk_res(0, 0, ST_DUP, 1)));
    directed.push_back(row(MODE_FRONT, 0, 63, 1, mk_res(0, 0, ST_DONE, 1)));
    directed.push_back(row(MODE_APPEND, 1, 2, 0, '0));
    directed.push_back(row(MODE_APPEND, 63, 0, 0, '0));
    directed.push_back(row(MODE_FRONT, 2, 0, 0, '0));
    directed.push_back(row(MODE_DEGREE, 0, 0, 1, mk_res(0, 3, ST_DONE, 1)));
    directed.push_back(row(MODE_SEARCH, 0, 0, 0, '0));
    directed.push_back(row(MODE_SEARCH, 2, 0, 0, '0));
    foreach (directed[k]) begin
      t = directed[k];
      send_op(t.op, t.u, t.v);
      if (t.known && last_pred !== t.res)
        report_mismatch($sformatf("table row %0d predicts %h", k, t.res));
    end

    // Fill node 5 to capacity, then hit the full-list cases.
    for (i = 0; i < MaxDegree; i++) send_op(MODE_APPEND, 5, i[5:0]);
    send_op(MODE_APPEND, 5, 7);
    send_op(MODE_FRONT, 5, 9);
    send_op(MODE_DEGREE, 5, 0);
    send_op(MODE_SEARCH, 5, 0);

    write_node_count(4);
    send_op(MODE_APPEND, 4, 0);
    send_op(MODE_APPEND, 0, 4);
    send_op(MODE_SEARCH, 0, 0);
    write_node_count(1);
    send_op(MODE_SEARCH, 0, 0);
    send_op(MODE_FRONT, 0, 0);
    write_node_count(0);
    send_op(MODE_DEGREE, 0, 0);
    write_node_count(127);
    send_op(MODE_SEARCH, 0, 0);

    for (r = 0; r < 6; r++) begin
      case (r)
        1: write_node_count(8);
        3: write_node_count($urandom_range(1, 64));
        4: write_node_count(100);
        5: write_node_count(64);
        default: ;
      endcase
      random_phase(62);
    end

    drain_results();
    $display("%0d operations sent, %0d searches, %0d results checked",
             transfers, searches, result_count);
    $display("node counts from 0 to 127 written; full lists and stale edges hit");
    if (errors == 0) begin
      $display("[graph_adjacency_bfs_engine] OK");
    end else begin
      $display("[graph_adjacency_bfs_engine] ERROR");
    end
    $finish;
  end

endmodule
